/* sv/dmaf_pkg.sv */
package dmaf_pkg;

  // Default ring depths
  localparam int unsigned MedianDepthDefault  = 5;
  localparam int unsigned AverageDepthDefault = 8;

  // Field widths
  localparam int unsigned DistW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned IdxW  = 3;

  // Saturation limit of the run counters
  localparam logic [CntW-1:0] SatMax = 8'd255;

  // Register indexes
  localparam logic [IdxW-1:0] RegMinValid    = 3'd0;
  localparam logic [IdxW-1:0] RegMaxValid    = 3'd1;
  localparam logic [IdxW-1:0] RegStop        = 3'd2;
  localparam logic [IdxW-1:0] RegStopConfirm = 3'd3;
  localparam logic [IdxW-1:0] RegJumpLimit   = 3'd4;
  localparam logic [IdxW-1:0] RegJumpConfirm = 3'd5;
  localparam logic [IdxW-1:0] RegWarn        = 3'd6;
  localparam logic [IdxW-1:0] RegSlow        = 3'd7;

  // Register reset values
  localparam logic [DistW-1:0] MinValidRst    = 16'd40;
  localparam logic [DistW-1:0] MaxValidRst    = 16'd4000;
  localparam logic [DistW-1:0] StopRst        = 16'd150;
  localparam logic [CntW-1:0]  StopConfirmRst = 8'd2;
  localparam logic [DistW-1:0] JumpLimitRst   = 16'd300;
  localparam logic [CntW-1:0]  JumpConfirmRst = 8'd3;
  localparam logic [DistW-1:0] WarnRst        = 16'd500;
  localparam logic [DistW-1:0] SlowRst        = 16'd300;

  // Result status codes
  typedef enum logic [1:0] {
    StFiltered = 2'd0,
    StClose    = 2'd1,
    StRange    = 2'd2,
    StJump     = 2'd3
  } status_e;

  // Flags held from the last accepted sample
  typedef struct packed {
    logic too_close;
    logic slow;
    logic warning;
    logic valid;
  } flags_t;

  // Sequencer states
  typedef enum logic [9:0] {
    SIdle  = 10'b00_0000_0001,
    SEval  = 10'b00_0000_0010,
    SMAddr = 10'b00_0000_0100,
    SMCand = 10'b00_0000_1000,
    SMCmp  = 10'b00_0001_0000,
    SJump  = 10'b00_0010_0000,
    SPush  = 10'b00_0100_0000,
    SDiv   = 10'b00_1000_0000,
    SFin   = 10'b01_0000_0000,
    SOut   = 10'b10_0000_0000
  } state_e;

endpackage

/* sv/distance_median_average_filter.sv */
// Range sample filter: close-run priority, range check, median, jump rejection
// and moving average.
// Input channel (in_valid_i/in_ready_o) carries one beat: raw_mm_i and time_ms_i.
// Output channel (out_valid_o/out_ready_i) returns exactly one result beat per
// input beat. The block works on one sample at a time: in_ready_o is high only
// while idle, and the result sits in registers until out_ready_i takes it; the
// next sample is taken the cycle after that.
// Steps from the input beat to out_valid_o: a range reject is decided in the
// evaluation step, and a close report adds a push. On the median path: evaluation,
// then a rank search over the N filled median entries (one compare per cycle,
// each candidate read and compared against every entry), then the jump check,
// where a jump reject ends. An accepted median adds a push, the bit-serial
// mean divider and a finishing step.
// Configuration writes (cfg_we_i) take effect at once and are expected only
// while the block is idle.
// Reset clears the counters, ring pointers and fills and the held results and loads
// the register defaults; ring memories are not cleared, but only filled entries are read.
module distance_median_average_filter #(
  parameter int unsigned MEDIAN_DEPTH  = dmaf_pkg::MedianDepthDefault,
  parameter int unsigned AVERAGE_DEPTH = dmaf_pkg::AverageDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dmaf_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [dmaf_pkg::DistW-1:0]  cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dmaf_pkg::DistW-1:0]  raw_mm_i,
  input  logic [dmaf_pkg::TimeW-1:0]  time_ms_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [dmaf_pkg::DistW-1:0]  filt_mm_o,
  output logic                        valid_res_o,
  output logic                        warning_o,
  output logic                        slow_o,
  output logic                        too_close_o,
  output logic [dmaf_pkg::TimeW-1:0]  last_valid_time_o,
  output logic [dmaf_pkg::TimeW-1:0]  accept_count_o
);
  import dmaf_pkg::*;

  localparam int unsigned MIdxW  = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int unsigned MFillW = $clog2(MEDIAN_DEPTH + 1);
  localparam int unsigned AIdxW  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int unsigned AFillW = $clog2(AVERAGE_DEPTH + 1);
  localparam int unsigned SumW   = DistW + $clog2(AVERAGE_DEPTH);
  localparam int unsigned DCntW  = $clog2(SumW);

  localparam logic [MIdxW-1:0]  MLast = MIdxW'(MEDIAN_DEPTH - 1);
  localparam logic [MFillW-1:0] MFull = MFillW'(MEDIAN_DEPTH);
  localparam logic [AIdxW-1:0]  ALast = AIdxW'(AVERAGE_DEPTH - 1);
  localparam logic [AFillW-1:0] AFull = AFillW'(AVERAGE_DEPTH);

  // Configuration registers
  logic [DistW-1:0] min_valid_q, max_valid_q, stop_q, jump_limit_q, warn_q, slow_q;
  logic [CntW-1:0]  stop_confirm_q, jump_confirm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q    <= MinValidRst;
      max_valid_q    <= MaxValidRst;
      stop_q         <= StopRst;
      stop_confirm_q <= StopConfirmRst;
      jump_limit_q   <= JumpLimitRst;
      jump_confirm_q <= JumpConfirmRst;
      warn_q         <= WarnRst;
      slow_q         <= SlowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinValid:    min_valid_q    <= cfg_data_i;
        RegMaxValid:    max_valid_q    <= cfg_data_i;
        RegStop:        stop_q         <= cfg_data_i;
        RegStopConfirm: stop_confirm_q <= cfg_data_i[CntW-1:0];
        RegJumpLimit:   jump_limit_q   <= cfg_data_i;
        RegJumpConfirm: jump_confirm_q <= cfg_data_i[CntW-1:0];
        RegWarn:        warn_q         <= cfg_data_i;
        RegSlow:        slow_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and filter state
  state_e            state_q, state_d;
  logic [DistW-1:0]  raw_q, val_q, cand_q, last_acc_q, held_dist_q;
  logic [TimeW-1:0]  time_q, held_time_q, total_q;
  logic [CntW-1:0]   close_run_q, jump_run_q;
  logic              close_path_q;
  status_e           status_q;
  flags_t            held_flags_q;
  logic [MIdxW-1:0]  med_ptr_q, i_q, j_q;
  logic [MFillW-1:0] med_fill_q, rank_q;
  logic [AIdxW-1:0]  avg_ptr_q;
  logic [AFillW-1:0] avg_fill_q, divisor_q;
  logic [SumW-1:0]   sum_q, quo_q;
  logic [AFillW-1:0] rem_q;
  logic [DCntW-1:0]  dcnt_q;

  // Ring memories, one write and one registered read each
  logic [DistW-1:0]  med_ring [MEDIAN_DEPTH];
  logic [DistW-1:0]  avg_ring [AVERAGE_DEPTH];
  logic [DistW-1:0]  med_rd_q, avg_rd_q;
  logic [MIdxW-1:0]  med_rd_addr;
  logic              med_we, avg_we;

  // Early decisions on the captured sample
  logic              is_close, out_of_range, close_path;
  logic [CntW-1:0]   close_run_d;
  assign is_close     = (raw_q != '0) && (raw_q <= stop_q);
  assign close_run_d  = !is_close ? '0 :
                        (close_run_q == SatMax) ? SatMax : close_run_q + 1'b1;
  assign close_path   = close_run_d >= stop_confirm_q;
  assign out_of_range = (raw_q < min_valid_q) || (raw_q > max_valid_q);

  // Rank compare: entries below the candidate, ties broken by position
  logic              less, j_last, found;
  logic [MFillW-1:0] rank_fin;
  assign less     = (med_rd_q < cand_q) || ((med_rd_q == cand_q) && (j_q < i_q));
  assign j_last   = MFillW'(j_q) == (med_fill_q - 1'b1);
  assign rank_fin = rank_q + MFillW'(less);
  assign found    = rank_fin == (med_fill_q >> 1);

  // Jump check against the last accepted value
  logic [DistW-1:0]  diff;
  logic              is_jump, jump_hold;
  logic [CntW-1:0]   jump_inc;
  assign diff      = (val_q >= last_acc_q) ? val_q - last_acc_q : last_acc_q - val_q;
  assign is_jump   = (last_acc_q != '0) && (diff > jump_limit_q);
  assign jump_inc  = (jump_run_q == SatMax) ? SatMax : jump_run_q + 1'b1;
  assign jump_hold = is_jump && (jump_inc < jump_confirm_q);

  // Running sum and fill of the average ring
  logic [SumW-1:0]   sum_d;
  logic [AFillW-1:0] avg_fill_d;
  assign sum_d      = sum_q + SumW'(val_q)
                    - ((avg_fill_q == AFull) ? SumW'(avg_rd_q) : '0);
  assign avg_fill_d = (avg_fill_q == AFull) ? AFull : avg_fill_q + 1'b1;

  // Restoring divider step
  logic [AFillW:0]   trial;
  logic              q_bit;
  logic [DistW-1:0]  mean;
  assign trial = {rem_q, quo_q[SumW-1]};
  assign q_bit = trial >= {1'b0, divisor_q};
  assign mean  = quo_q[DistW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:  if (in_valid_i) state_d = SEval;
      SEval: begin
        if (close_path)        state_d = SPush;
        else if (out_of_range) state_d = SOut;
        else                   state_d = SMAddr;
      end
      SMAddr: state_d = SMCand;
      SMCand: state_d = SMCmp;
      SMCmp: begin
        if (j_last) state_d = found ? SJump : SMAddr;
      end
      SJump:  state_d = jump_hold ? SOut : SPush;
      SPush:  state_d = close_path_q ? SOut : SDiv;
      SDiv:   if (dcnt_q == '0) state_d = SFin;
      SFin:   state_d = SOut;
      SOut:   if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Median read address
  always_comb begin
    med_rd_addr = '0;
    if (state_q == SMAddr) med_rd_addr = i_q;
    else if (state_q == SMCmp && !j_last) med_rd_addr = MIdxW'(j_q + 1'b1);
  end

  assign med_we = (state_q == SEval) && !close_path && !out_of_range;
  assign avg_we = (state_q == SPush);

  // Memories
  always_ff @(posedge clk_i) begin
    if (med_we) med_ring[med_ptr_q] <= raw_q;
    med_rd_q <= med_ring[med_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (avg_we) avg_ring[avg_ptr_q] <= val_q;
    avg_rd_q <= avg_ring[avg_ptr_q];
  end

  // Control and held result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      close_run_q  <= '0;
      jump_run_q   <= '0;
      close_path_q <= 1'b0;
      status_q     <= StFiltered;
      med_ptr_q    <= '0;
      med_fill_q   <= '0;
      avg_ptr_q    <= '0;
      avg_fill_q   <= '0;
      sum_q        <= '0;
      last_acc_q   <= '0;
      held_dist_q  <= '0;
      held_flags_q <= '0;
      held_time_q  <= '0;
      total_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      rank_q       <= '0;
      dcnt_q       <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        SEval: begin
          close_run_q  <= close_run_d;
          close_path_q <= close_path;
          val_q        <= raw_q;
          i_q          <= '0;
          if (close_path) begin
            status_q <= StClose;
          end else if (out_of_range) begin
            status_q <= StRange;
          end else begin
            med_ptr_q <= (med_ptr_q == MLast) ? '0 : med_ptr_q + 1'b1;
            if (med_fill_q != MFull) med_fill_q <= med_fill_q + 1'b1;
          end
        end
        SMCand: begin
          cand_q <= med_rd_q;
          j_q    <= '0;
          rank_q <= '0;
        end
        SMCmp: begin
          rank_q <= rank_fin;
          j_q    <= MIdxW'(j_q + 1'b1);
          if (j_last) begin
            if (found) val_q <= cand_q;
            else       i_q   <= MIdxW'(i_q + 1'b1);
          end
        end
        SJump: begin
          if (is_jump) jump_run_q <= jump_inc;
          else         jump_run_q <= '0;
          if (jump_hold) status_q <= StJump;
          else           status_q <= StFiltered;
        end
        SPush: begin
          avg_ptr_q  <= (avg_ptr_q == ALast) ? '0 : avg_ptr_q + 1'b1;
          avg_fill_q <= avg_fill_d;
          sum_q      <= sum_d;
          last_acc_q <= val_q;
          quo_q      <= sum_d;
          rem_q      <= '0;
          divisor_q  <= avg_fill_d;
          dcnt_q     <= DCntW'(SumW - 1);
          if (close_path_q) begin
            held_dist_q  <= val_q;
            held_flags_q <= '{too_close: 1'b1, slow: 1'b1, warning: 1'b1, valid: 1'b1};
            held_time_q  <= time_q;
            total_q      <= total_q + 1'b1;
          end
        end
        SDiv: begin
          quo_q  <= {quo_q[SumW-2:0], q_bit};
          rem_q  <= q_bit ? AFillW'(trial - {1'b0, divisor_q}) : AFillW'(trial);
          dcnt_q <= dcnt_q - 1'b1;
        end
        SFin: begin
          held_dist_q  <= mean;
          held_flags_q <= '{too_close: close_run_q >= stop_confirm_q,
                            slow:      mean <= slow_q,
                            warning:   mean <= warn_q,
                            valid:     1'b1};
          held_time_q  <= time_q;
          total_q      <= total_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q  <= raw_mm_i;
      time_q <= time_ms_i;
    end
  end

  // Ports
  assign in_ready_o        = state_q == SIdle;
  assign out_valid_o       = state_q == SOut;
  assign status_o          = status_q;
  assign filt_mm_o         = held_dist_q;
  assign valid_res_o       = held_flags_q.valid;
  assign warning_o         = held_flags_q.warning;
  assign slow_o            = held_flags_q.slow;
  assign too_close_o       = held_flags_q.too_close;
  assign last_valid_time_o = held_time_q;
  assign accept_count_o    = total_q;

endmodule

/* sv/dmaf_checker.sv */
module dmaf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic                        valid_res_o,
  input logic                        warning_o,
  input logic                        slow_o,
  input logic                        too_close_o
);
  import dmaf_pkg::*;

  // One sample in flight: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A taken input beat closes the input side
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a beat");

  // Exactly one result beat per sample
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("second result beat for one sample");

  // Close report sets every flag
  a_close_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StClose) |->
      (valid_res_o && warning_o && slow_o && too_close_o))
    else $error("close report without all flags");

  // Filtered acceptance is valid and never close
  a_filt_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StFiltered) |-> (valid_res_o && !too_close_o))
    else $error("filtered result with bad flags");

endmodule

bind distance_median_average_filter dmaf_checker u_dmaf_checker (.*);

/* sim/tb_top.sv */
module tb_top;
  import dmaf_pkg::*;

  localparam int unsigned MedDepth    = MedianDepthDefault;
  localparam int unsigned AvgDepth    = AverageDepthDefault;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned DirCount    = 18;

  // One result beat as the block reports it
  typedef struct packed {
    status_e          status;
    logic [DistW-1:0] filt_mm;
    logic             valid;
    logic             warning;
    logic             slow;
    logic             too_close;
    logic [TimeW-1:0] stamp;
    logic [31:0]      count;
  } result_t;

  // One directed sample; typed rows carry their result, others go to the filter model
  typedef struct packed {
    logic [DistW-1:0] raw;
    logic [TimeW-1:0] stamp;
    logic             typed;
    result_t          res;
  } row_t;

  typedef struct packed {
    logic [DistW-1:0] min_mm;
    logic [DistW-1:0] max_mm;
    logic [DistW-1:0] stop_mm;
    logic [CntW-1:0]  stop_cnf;
    logic [DistW-1:0] jump_mm;
    logic [CntW-1:0]  jump_cnf;
    logic [DistW-1:0] warn_mm;
    logic [DistW-1:0] slow_mm;
  } filt_cfg_t;

  localparam filt_cfg_t DefaultCfg = '{MinValidRst, MaxValidRst, StopRst, StopConfirmRst,
                                       JumpLimitRst, JumpConfirmRst, WarnRst, SlowRst};

  localparam result_t Untyped = '0;
  // nothing accepted yet: all held fields read zero
  localparam result_t RangeBeforeAny = '{StRange, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0};

  localparam row_t DirRows [DirCount] = '{
    '{16'd0,     32'd0,           1'b1, RangeBeforeAny},
    '{16'hFFFF,  32'hFFFF_FFFF,   1'b1, RangeBeforeAny},
    '{16'd39,    32'd1,           1'b1, RangeBeforeAny},   // close but below min
    '{16'd4001,  32'd2,           1'b1, RangeBeforeAny},
    // first acceptance, no reference yet so no jump check
    '{16'd100,   32'd10,          1'b1,
      '{StFiltered, 16'd100, 1'b1, 1'b1, 1'b1, 1'b0, 32'd10, 32'd1}},
    // close run reaches confirm count
    '{16'd100,   32'd20,          1'b1,
      '{StClose, 16'd100, 1'b1, 1'b1, 1'b1, 1'b1, 32'd20, 32'd2}},
    '{16'd150,   32'd30,          1'b1,
      '{StClose, 16'd150, 1'b1, 1'b1, 1'b1, 1'b1, 32'd30, 32'd3}},
    '{16'd151,   32'd40,          1'b0, Untyped},
    '{16'd4000,  32'd50,          1'b0, Untyped},
    // median jumps: rejected until the jump run confirms
    '{16'd4000,  32'd60,          1'b0, Untyped},
    '{16'd4000,  32'd70,          1'b0, Untyped},
    '{16'd4000,  32'd80,          1'b0, Untyped},
    '{16'd4000,  32'd90,          1'b0, Untyped},
    '{16'd40,    32'd100,         1'b0, Untyped},
    // close priority below the valid range
    '{16'd1,     32'd110,         1'b0, Untyped},
    '{16'd2000,  32'd120,         1'b0, Untyped},
    '{16'hFFFF,  32'd130,         1'b0, Untyped},
    '{16'd0,     32'hFFFF_FFFF,   1'b0, Untyped}
  };

  // DUT ports
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i   = '0;
  logic [DistW-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [DistW-1:0] raw_mm_i    = '0;
  logic [TimeW-1:0] time_ms_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       status_o;
  logic [DistW-1:0] filt_mm_o;
  logic             valid_res_o;
  logic             warning_o;
  logic             slow_o;
  logic             too_close_o;
  logic [TimeW-1:0] last_valid_time_o;
  logic [TimeW-1:0] accept_count_o;

  // Filter model state
  filt_cfg_t        cfg;
  logic [DistW-1:0] med_ring [MedDepth];
  int unsigned      med_ptr, med_fill;
  logic [DistW-1:0] avg_ring [AvgDepth];
  int unsigned      avg_ptr, avg_fill;
  logic [DistW-1:0] last_acc;
  int unsigned      close_run, jump_run;
  logic [DistW-1:0] held_dist;
  flags_t           held_flags;
  logic [TimeW-1:0] held_time;
  logic [31:0]      acc_total;

  // Stimulus shaping
  int unsigned      idle_pct   = 0;
  int unsigned      stall_pct  = 0;
  int unsigned      zero_share = 3;
  int unsigned      close_left = 0;
  logic [DistW-1:0] track_mm   = 16'd1000;
  logic [TimeW-1:0] now_ms     = '0;

  result_t          report_q [$];
  result_t          want;
  int unsigned      mismatches = 0;
  int unsigned      cycles     = 0;

  distance_median_average_filter DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Filter model
  task automatic model_reset();
    cfg = DefaultCfg;
    foreach (med_ring[i]) med_ring[i] = '0;
    foreach (avg_ring[i]) avg_ring[i] = '0;
    med_ptr = 0; med_fill = 0; avg_ptr = 0; avg_fill = 0;
    last_acc = '0; close_run = 0; jump_run = 0;
    held_dist = '0; held_flags = '0; held_time = '0; acc_total = '0;
  endtask

  function automatic result_t held_result(input status_e s);
    result_t r;
    r.status    = s;
    r.filt_mm   = held_dist;
    r.valid     = held_flags.valid;
    r.warning   = held_flags.warning;
    r.slow      = held_flags.slow;
    r.too_close = held_flags.too_close;
    r.stamp     = held_time;
    r.count     = acc_total;
    return r;
  endfunction

  // push into the average ring, floor mean of the filled entries
  function automatic logic [DistW-1:0] mean_push(input logic [DistW-1:0] v);
    int unsigned sum;
    sum = 0;
    avg_ring[avg_ptr] = v;
    avg_ptr = (avg_ptr + 1) % AvgDepth;
    if (avg_fill < AvgDepth) avg_fill++;
    for (int i = 0; i < avg_fill; i++) sum += avg_ring[i];
    return DistW'(sum / avg_fill);
  endfunction

  task automatic filter_sample(input logic [DistW-1:0] raw, input logic [TimeW-1:0] now,
                               output result_t r);
    logic [DistW-1:0] sorted [MedDepth];
    logic [DistW-1:0] tmp, med, avg;
    int unsigned      dlt;
    // close run, saturating
    if (raw != 0 && raw <= cfg.stop_mm) begin
      if (close_run < SatMax) close_run++;
    end else begin
      close_run = 0;
    end
    // close priority skips range, median and jump checks
    if (close_run >= cfg.stop_cnf) begin
      avg        = mean_push(raw);
      last_acc   = raw;
      held_dist  = raw;
      held_flags = 4'hF;
      held_time  = now;
      acc_total++;
      r = held_result(StClose);
      return;
    end
    if (raw < cfg.min_mm || raw > cfg.max_mm) begin
      r = held_result(StRange);
      return;
    end
    // median ring, upper middle of the filled entries
    med_ring[med_ptr] = raw;
    med_ptr = (med_ptr + 1) % MedDepth;
    if (med_fill < MedDepth) med_fill++;
    for (int i = 0; i < med_fill; i++) sorted[i] = med_ring[i];
    for (int i = 0; i < med_fill; i++) begin
      for (int j = i + 1; j < med_fill; j++) begin
        if (sorted[j] < sorted[i]) begin
          tmp = sorted[i]; sorted[i] = sorted[j]; sorted[j] = tmp;
        end
      end
    end
    med = sorted[med_fill / 2];
    // jump check, skipped while there is no reference
    dlt = (med >= last_acc) ? med - last_acc : last_acc - med;
    if (last_acc != 0 && dlt > cfg.jump_mm) begin
      if (jump_run < SatMax) jump_run++;
      if (jump_run < cfg.jump_cnf) begin
        r = held_result(StJump);
        return;
      end
    end else begin
      jump_run = 0;
    end
    avg                  = mean_push(med);
    last_acc             = med;
    held_dist            = avg;
    held_flags.valid     = 1'b1;
    held_flags.warning   = (avg <= cfg.warn_mm);
    held_flags.slow      = (avg <= cfg.slow_mm);
    held_flags.too_close = (close_run >= cfg.stop_cnf);
    held_time            = now;
    acc_total++;
    r = held_result(StFiltered);
  endtask

  // Sensor-like distances: a slowly moving target with noise, close bursts,
  // relocations, out-of-range and zero readings
  function automatic logic [DistW-1:0] next_distance();
    int          v;
    int unsigned pick;
    if (close_left != 0) begin
      close_left--;
      v = (cfg.stop_mm == 0) ? 1 : int'($urandom_range(1, cfg.stop_mm));
    end else begin
      pick = $urandom_range(99);
      if (pick < zero_share) begin
        v = 0;
      end else if (pick < zero_share + 8) begin
        close_left = $urandom_range(0, 5);
        v = (cfg.stop_mm == 0) ? 1 : int'($urandom_range(1, cfg.stop_mm));
      end else if (pick < zero_share + 16) begin
        v = int'($urandom_range(0, 65535));
      end else if (pick < zero_share + 22) begin
        v = $urandom_range(1) ? int'($urandom_range(0, cfg.min_mm))
                              : int'($urandom_range(cfg.max_mm, 65535));
      end else begin
        if (pick < zero_share + 28) begin
          track_mm = DistW'($urandom_range(cfg.min_mm, cfg.max_mm));
        end
        v = int'(track_mm) + int'($urandom_range(0, 60)) - 30;
      end
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    if (zero_share == 0 && v == 0) v = 1;
    return DistW'(v);
  endfunction

  function automatic logic [TimeW-1:0] next_stamp();
    if ($urandom_range(9) == 0) now_ms = $urandom();
    else now_ms += $urandom_range(1, 40);
    return now_ms;
  endfunction

  // Send one input beat, record the predicted report, then maybe idle
  task automatic send_sample(input row_t row);
    result_t     r;
    int unsigned gap;
    in_valid_i <= 1'b1;
    raw_mm_i   <= row.raw;
    time_ms_i  <= row.stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_sample(row.raw, row.stamp, r);
    report_q.push_back(row.typed ? row.res : r);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 100) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain all reports and wait until the block is idle again
  task automatic settle();
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(input filt_cfg_t c);
    logic [DistW-1:0] vals [8];
    vals[RegMinValid]    = c.min_mm;
    vals[RegMaxValid]    = c.max_mm;
    vals[RegStop]        = c.stop_mm;
    vals[RegStopConfirm] = DistW'(c.stop_cnf);
    vals[RegJumpLimit]   = c.jump_mm;
    vals[RegJumpConfirm] = DistW'(c.jump_cnf);
    vals[RegWarn]        = c.warn_mm;
    vals[RegSlow]        = c.slow_mm;
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= IdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  task automatic run_phase(input filt_cfg_t c, input int unsigned items,
                           input int unsigned snd_idle, input int unsigned rcv_stall,
                           input int unsigned zpct);
    row_t row;
    settle();
    load_config(c);
    idle_pct   = snd_idle;
    stall_pct  = rcv_stall;
    zero_share = zpct;
    close_left = 0;
    repeat (items) begin
      row       = '0;
      row.raw   = next_distance();
      row.stamp = next_stamp();
      send_sample(row);
    end
  endtask

  // Receiver side: random stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result beat with the oldest predicted report
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        $error("result beat with no report pending");
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (filt_mm_o !== want.filt_mm) begin
          $error("filt_mm: expected %0d, got %0d", want.filt_mm, filt_mm_o);
          mismatches++;
        end
        if (valid_res_o !== want.valid) begin
          $error("valid_res: expected %0b, got %0b", want.valid, valid_res_o);
          mismatches++;
        end
        if (warning_o !== want.warning) begin
          $error("warning: expected %0b, got %0b", want.warning, warning_o);
          mismatches++;
        end
        if (slow_o !== want.slow) begin
          $error("slow: expected %0b, got %0b", want.slow, slow_o);
          mismatches++;
        end
        if (too_close_o !== want.too_close) begin
          $error("too_close: expected %0b, got %0b", want.too_close, too_close_o);
          mismatches++;
        end
        if (last_valid_time_o !== want.stamp) begin
          $error("last_valid_time: expected %0d, got %0d", want.stamp, last_valid_time_o);
          mismatches++;
        end
        if (accept_count_o !== want.count) begin
          $error("accept_count: expected %0d, got %0d", want.count, accept_count_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    filt_cfg_t rnd_cfg;
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples on reset settings
    foreach (DirRows[k]) send_sample(DirRows[k]);

    // reset settings written back, no idling
    run_phase(DefaultCfg, 200, 0, 0, 3);
    // zero stop confirm: every sample is close priority
    run_phase('{16'hFFFF, 16'd0, 16'd150, 8'd0, 16'd300, 8'd3, 16'd500, 16'd300},
              40, 88, 0, 3);
    // inverted range: only close priority gets through
    run_phase('{16'd3000, 16'd1000, 16'd150, 8'd2, 16'd300, 8'd3, 16'd500, 16'd300},
              40, 88, 0, 3);
    // no close samples, zero jump limit: jump run climbs to saturation
    run_phase('{16'd0, 16'hFFFF, 16'd0, 8'd1, 16'd0, 8'd255, 16'hFFFF, 16'd0},
              280, 0, 88, 3);
    // every nonzero sample is close: close run saturates
    run_phase('{16'd0, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 8'd1, 16'd0, 16'hFFFF},
              270, 10, 10, 0);
    // zero jump confirm accepts every jump
    run_phase('{16'd100, 16'd5000, 16'd400, 8'd1, 16'd100, 8'd0, 16'd1000, 16'd600},
              60, 0, 0, 3);
    // random settings
    rnd_cfg.min_mm   = DistW'($urandom_range(0, 500));
    rnd_cfg.max_mm   = DistW'($urandom_range(1000, 65535));
    rnd_cfg.stop_mm  = DistW'($urandom_range(0, 1000));
    rnd_cfg.stop_cnf = CntW'($urandom_range(1, 6));
    rnd_cfg.jump_mm  = DistW'($urandom_range(0, 2000));
    rnd_cfg.jump_cnf = CntW'($urandom_range(0, 8));
    rnd_cfg.warn_mm  = DistW'($urandom_range(0, 65535));
    rnd_cfg.slow_mm  = DistW'($urandom_range(0, 65535));
    run_phase(rnd_cfg, 60, 0, 88, 3);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dmaf_pkg.sv
sv/distance_median_average_filter.sv
sv/dmaf_checker.sv
sim/tb_top.sv
